// ===== rtl/core/sca_pkg.sv =====
`default_nettype none
package sca_pkg;

   // field widths fixed by the interface
   localparam int CHAN_W      = 5;
   localparam int MASK_W      = 32;
   localparam int CNT_W       = 6;
   localparam int DEF_CHANNELS = 32;

   // request transfer
   typedef struct packed {
      logic [CHAN_W-1:0] source_channel;
      logic [MASK_W-1:0] occupied_mask;
   } sca_req_type;

   // result transfer
   typedef struct packed {
      logic              routed;
      logic [CHAN_W-1:0] destination;
      logic              relocated;
   } sca_rsp_type;

   // table update from the decision logic
   typedef struct packed {
      logic              last_we;
      logic              claim_we;
      logic [CHAN_W-1:0] source;
      logic [CHAN_W-1:0] chan;
   } sca_update_type;

endpackage
`default_nettype wire

// ===== rtl/core/sca_tables.sv =====
`default_nettype none
module sca_tables #(
   parameter int CHANNELS = sca_pkg::DEF_CHANNELS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [sca_pkg::CNT_W-1:0]   csr_write_data,
   input  wire sca_pkg::sca_update_type     update,
   input  wire logic [sca_pkg::CHAN_W-1:0]  read_source,
   output logic [sca_pkg::CNT_W-1:0]        count,
   output logic [CHANNELS-1:0]              owner_valid,
   output logic [sca_pkg::CHAN_W-1:0]       owner [CHANNELS],
   output logic [sca_pkg::CHAN_W-1:0]       last_used
);
   import sca_pkg::*;

   localparam int IDX_W = $clog2(CHANNELS);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CHANNELS-1:0] valid_ff;
   logic [CHAN_W-1:0] owner_ff [CHANNELS];
   logic [CHAN_W-1:0] last_ff [CHANNELS];

   // written count saturates at the channel count
   always_comb begin
      if (csr_write_data > CNT_W'(CHANNELS)) begin
         count_in = CNT_W'(CHANNELS);
      end else begin
         count_in = csr_write_data;
      end
   end

   // tables: rebuilt on reset or count write, else per-transfer update
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            valid_ff[i] <= 1'b0;
            owner_ff[i] <= '0;
            last_ff[i]  <= CHAN_W'(i);
         end
      end else if (csr_write_enable) begin
         count_ff <= count_in;
         for (int i = 0; i < CHANNELS; i++) begin
            valid_ff[i] <= CNT_W'(i) < count_in;
            owner_ff[i] <= (CNT_W'(i) < count_in) ? CHAN_W'(i) : '0;
            last_ff[i]  <= CHAN_W'(i);
         end
      end else begin
         if (update.claim_we) begin
            valid_ff[update.chan[IDX_W-1:0]] <= 1'b1;
            owner_ff[update.chan[IDX_W-1:0]] <= update.source;
         end
         if (update.last_we) begin
            last_ff[update.source[IDX_W-1:0]] <= update.chan;
         end
      end
   end

   assign count       = count_ff;
   assign owner_valid = valid_ff;
   assign owner       = owner_ff;
   assign last_used   = last_ff[read_source[IDX_W-1:0]];

endmodule
`default_nettype wire

// ===== rtl/core/sca_pick.sv =====
`default_nettype none
module sca_pick #(
   parameter int CHANNELS = sca_pkg::DEF_CHANNELS
) (
   input  wire logic                        req_valid,
   input  wire sca_pkg::sca_req_type        req,
   input  wire logic [sca_pkg::CNT_W-1:0]   count,
   input  wire logic [CHANNELS-1:0]         owner_valid,
   input  wire logic [sca_pkg::CHAN_W-1:0]  owner [CHANNELS],
   input  wire logic [sca_pkg::CHAN_W-1:0]  last_used,
   output sca_pkg::sca_rsp_type             rsp,
   output sca_pkg::sca_update_type          update
);
   import sca_pkg::*;

   localparam int IDX_W = $clog2(CHANNELS);

   // index of the lowest set bit, parallel one-hot isolate and encode
   function automatic logic [CHAN_W-1:0] lowest(input logic [CHANNELS-1:0] v);
      logic [CHANNELS-1:0] iso;
      logic [CHAN_W-1:0]   idx;
      iso = v & (~v + 1'b1);
      idx = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (iso[i]) begin
            idx = idx | CHAN_W'(i);
         end
      end
      return idx;
   endfunction

   logic [CHANNELS-1:0] free_vec;
   logic [CHANNELS-1:0] own_vec;
   logic [CHANNELS-1:0] open_vec;
   logic                src_ok;
   logic                sticky;
   logic                found;
   logic [CHAN_W-1:0]   dest;

   // candidate vectors per channel
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         free_vec[i] = ~req.occupied_mask[i];
         own_vec[i]  = owner_valid[i] && (owner[i] == req.source_channel) && free_vec[i];
         open_vec[i] = !owner_valid[i] && free_vec[i];
      end
   end

   assign src_ok = {1'b0, req.source_channel} < count;
   assign sticky = free_vec[last_used[IDX_W-1:0]];

   // sticky channel, then owned channel, then claim an unowned one
   always_comb begin
      update        = '0;
      update.source = req.source_channel;
      found         = 1'b0;
      dest          = '0;
      priority if (!req_valid || !src_ok) begin
         found = 1'b0;
      end else if (sticky) begin
         found = 1'b1;
         dest  = last_used;
      end else if (|own_vec) begin
         found          = 1'b1;
         dest           = lowest(own_vec);
         update.last_we = 1'b1;
      end else if (|open_vec) begin
         found           = 1'b1;
         dest            = lowest(open_vec);
         update.last_we  = 1'b1;
         update.claim_we = 1'b1;
      end else begin
         found = 1'b0;
      end
      update.chan = dest;
   end

   // result fields
   assign rsp.routed      = found;
   assign rsp.destination = dest;
   assign rsp.relocated   = found && (dest != req.source_channel);

endmodule
`default_nettype wire

// ===== rtl/core/sticky_channel_spill_allocator_unit.sv =====
`default_nettype none
// channel   ports                       direction  handshake
// request   start, busy, req_data       in         start && !busy
// result    rsp_strobe, rsp_data        out        strobe, one cycle
// config    csr_write_enable/_data      in         write enable
//
// one request per cycle; each result passes the input register, then the table
// lookup and priority search into the result register, with the tables updated
// at that same edge
// busy stays low; the receiver cannot stall, so results never back up
// synchronous reset clears the count and rebuilds the tables
module sticky_channel_spill_allocator_unit #(
   parameter int CHANNELS = sca_pkg::DEF_CHANNELS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire sca_pkg::sca_req_type       req_data,
   output logic                            rsp_strobe,
   output sca_pkg::sca_rsp_type            rsp_data,
   input  wire logic                       csr_write_enable,
   input  wire logic [sca_pkg::CNT_W-1:0]  csr_write_data
);
   import sca_pkg::*;

   logic           req_valid_ff;
   sca_req_type    req_ff;
   logic           rsp_valid_ff;
   sca_rsp_type    rsp_ff;
   sca_rsp_type    rsp_in;
   sca_update_type update;
   logic [CNT_W-1:0]  count;
   logic [CHANNELS-1:0] owner_valid;
   logic [CHAN_W-1:0] owner [CHANNELS];
   logic [CHAN_W-1:0] last_used;

   assign busy = 1'b0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   sca_tables #(
      .CHANNELS (CHANNELS)
   ) u_tables (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .update           (update),
      .read_source      (req_ff.source_channel),
      .count            (count),
      .owner_valid      (owner_valid),
      .owner            (owner),
      .last_used        (last_used)
   );

   sca_pick #(
      .CHANNELS (CHANNELS)
   ) u_pick (
      .req_valid   (req_valid_ff),
      .req         (req_ff),
      .count       (count),
      .owner_valid (owner_valid),
      .owner       (owner),
      .last_used   (last_used),
      .rsp         (rsp_in),
      .update      (update)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/sca_checker.sv =====
`default_nettype none
module sca_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire sca_pkg::sca_req_type       req_data,
   input wire logic                       rsp_strobe,
   input wire sca_pkg::sca_rsp_type       rsp_data
);

   // every request transfer gives a result through the input and result registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("request transfer without result");

   // no result without an earlier request transfer through the input and result registers
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without request transfer");

   // failed result carries zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.routed) |->
         (rsp_data.destination == '0) && !rsp_data.relocated)
      else $error("failed result with non-zero fields");

   // relocation flag matches the source of the matching request
   a_relocated: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.relocated ==
         (rsp_data.routed &&
          (rsp_data.destination != $past(req_data.source_channel, 2))))
      else $error("relocation flag wrong");

endmodule

bind sticky_channel_spill_allocator_unit sca_checker u_sca_checker (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import sca_pkg::*;

   localparam int CHAN_COUNT   = DEF_CHANNELS;
   localparam int RANDOM_ITEMS = 1900;
   localparam int QUIET_TAIL   = 250;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SHOW_MAX     = 10;

   typedef enum logic [1:0] {
      STEP_REQ,
      STEP_CFG,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      sca_req_type   req;
      logic [CNT_W-1:0] count;
   } plan_step_type;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             start            = 1'b0;
   logic             busy;
   sca_req_type      req_data         = '0;
   logic             rsp_strobe;
   sca_rsp_type      rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [CNT_W-1:0] csr_write_data   = '0;

   // planned stimulus and predicted routes in arrival order
   plan_step_type plan_q[$];
   sca_rsp_type   predicted_routes[$];

   // shadow of the allocator tables
   int unsigned      shadow_count;
   logic             shadow_owned[CHAN_COUNT];
   logic [CHAN_W-1:0] shadow_owner[CHAN_COUNT];
   logic [CHAN_W-1:0] shadow_last[CHAN_COUNT];

   // driver bookkeeping
   int unsigned gap_left   = 0;
   int unsigned gap_pct    = 20;
   int unsigned reqs_sent  = 0;
   int unsigned total_reqs = 0;
   int          in_flight  = 0;

   // results and statistics
   int unsigned err_count   = 0;
   int unsigned shown_count = 0;
   int unsigned n_req       = 0;
   int unsigned n_routed    = 0;
   int unsigned n_reloc     = 0;
   int unsigned n_refused   = 0;
   int unsigned n_cfg       = 0;
   int unsigned stall_cycles = 0;

   sticky_channel_spill_allocator_unit #(
      .CHANNELS(CHAN_COUNT)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // rebuild the tables after a count write, saturating at the channel count
   function automatic void rebuild_tables(logic [CNT_W-1:0] value);
      int i;
      shadow_count = (value > CHAN_COUNT) ? CHAN_COUNT : value;
      for (i = 0; i < CHAN_COUNT; i++) begin
         shadow_last[i]  = i[CHAN_W-1:0];
         shadow_owned[i] = (i < shadow_count);
         shadow_owner[i] = (i < shadow_count) ? i[CHAN_W-1:0] : '0;
      end
   endfunction

   // sticky channel first, then lowest free owned channel, then claim a free one
   function automatic sca_rsp_type predict_route(sca_req_type rq);
      sca_rsp_type       res;
      logic [CHAN_W-1:0] src;
      logic [CHAN_W-1:0] dst;
      logic              hit;
      int                i;
      res = '0;
      src = rq.source_channel;
      hit = 1'b0;
      dst = '0;
      if (src < shadow_count) begin
         dst = shadow_last[src];
         if (dst < CHAN_COUNT && !rq.occupied_mask[dst])
            hit = 1'b1;
         for (i = 0; i < CHAN_COUNT; i++) begin
            if (!hit && shadow_owned[i] && shadow_owner[i] == src && !rq.occupied_mask[i]) begin
               shadow_last[src] = i[CHAN_W-1:0];
               dst = i[CHAN_W-1:0];
               hit = 1'b1;
            end
         end
         for (i = 0; i < CHAN_COUNT; i++) begin
            if (!hit && !shadow_owned[i] && !rq.occupied_mask[i]) begin
               shadow_owned[i]  = 1'b1;
               shadow_owner[i]  = src;
               shadow_last[src] = i[CHAN_W-1:0];
               dst = i[CHAN_W-1:0];
               hit = 1'b1;
            end
         end
         if (hit) begin
            res.routed      = 1'b1;
            res.destination = dst;
            res.relocated   = (dst != src);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, sca_rsp_type want, sca_rsp_type got);
      err_count++;
      if (shown_count < SHOW_MAX) begin
         shown_count++;
         $display("mismatch (%s): expected routed=%0b dest=%0d reloc=%0b,",
                  what, want.routed, want.destination, want.relocated,
                  " got routed=%0b dest=%0d reloc=%0b",
                  got.routed, got.destination, got.relocated);
      end
   endtask

   // driver: one transfer or one register write at a time, idle bursts between
   always @(posedge clock) begin : driver
      logic             start_n;
      sca_req_type      data_n;
      logic             we_n;
      logic [CNT_W-1:0] wdata_n;
      int               flight_n;
      start_n  = start;
      data_n   = req_data;
      we_n     = 1'b0;
      wdata_n  = csr_write_data;
      flight_n = in_flight + ((start && !busy) ? 1 : 0) - (rsp_strobe ? 1 : 0);
      if (reset) begin
         start_n  = 1'b0;
         flight_n = 0;
      end else begin
         if (start && !busy)
            start_n = 1'b0;
         if (!start_n) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (plan_q.size() != 0) begin
               case (plan_q[0].kind)
                  STEP_REQ: begin
                     start_n = 1'b1;
                     data_n  = plan_q[0].req;
                     void'(plan_q.pop_front());
                     reqs_sent++;
                     if (reqs_sent % 150 == 0) begin
                        case ($urandom_range(0, 3))
                           0: gap_pct = 0;
                           1: gap_pct = 5;
                           2: gap_pct = 25;
                           default: gap_pct = 60;
                        endcase
                     end
                     if (reqs_sent + QUIET_TAIL < total_reqs &&
                         $urandom_range(0, 99) < gap_pct)
                        gap_left = $urandom_range(1, 19);
                  end
                  STEP_CFG: begin
                     // only once every transfer in flight has produced its result
                     if (!start && flight_n <= 0) begin
                        we_n    = 1'b1;
                        wdata_n = plan_q[0].count;
                        void'(plan_q.pop_front());
                     end
                  end
                  default: begin
                     if (!start && flight_n <= 0)
                        void'(plan_q.pop_front());
                  end
               endcase
            end
         end
      end
      in_flight = flight_n;
      start            <= start_n;
      req_data         <= data_n;
      csr_write_enable <= we_n;
      csr_write_data   <= wdata_n;
   end

   // monitor: check results, track register writes, predict accepted transfers
   always @(posedge clock) begin : monitor
      sca_rsp_type want;
      if (reset) begin
         rebuild_tables('0);
      end else begin
         if (rsp_strobe) begin
            if (rsp_data.routed)
               n_routed++;
            else
               n_refused++;
            if (rsp_data.relocated)
               n_reloc++;
            if (predicted_routes.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_data);
            end else begin
               want = predicted_routes.pop_front();
               if (rsp_data.routed !== want.routed)
                  report_mismatch("routed", want, rsp_data);
               else if (rsp_data.destination !== want.destination)
                  report_mismatch("destination", want, rsp_data);
               else if (rsp_data.relocated !== want.relocated)
                  report_mismatch("relocated", want, rsp_data);
            end
         end
         if (csr_write_enable) begin
            rebuild_tables(csr_write_data);
            n_cfg++;
         end
         if (start && !busy) begin
            predicted_routes.push_back(predict_route(req_data));
            n_req++;
         end
      end
   end

   // watchdog on cycles with no transfer, result or write
   always @(posedge clock) begin : watchdog
      if ((start && !busy) || rsp_strobe || csr_write_enable)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic add_req(logic [CHAN_W-1:0] src, logic [MASK_W-1:0] mask);
      plan_step_type s;
      s.kind = STEP_REQ;
      s.req.source_channel = src;
      s.req.occupied_mask  = mask;
      s.count = '0;
      plan_q.push_back(s);
      total_reqs++;
   endtask

   task automatic add_cfg(logic [CNT_W-1:0] value);
      plan_step_type s;
      s.kind  = STEP_CFG;
      s.req   = '0;
      s.count = value;
      plan_q.push_back(s);
   endtask

   task automatic add_drain();
      plan_step_type s;
      s.kind  = STEP_DRAIN;
      s.req   = '0;
      s.count = '0;
      plan_q.push_back(s);
   endtask

   // busy masks from empty to full, with bias towards crowded rows
   function automatic logic [MASK_W-1:0] pick_mask(logic [CHAN_W-1:0] src);
      logic [MASK_W-1:0] m;
      case ($urandom_range(0, 6))
         0: m = $urandom;
         1: m = $urandom | $urandom | $urandom;
         2: m = $urandom & $urandom & $urandom;
         3: m = ~(32'h1 << $urandom_range(0, 31));
         4: m = $urandom_range(0, 1) ? '1 : '0;
         5: m = $urandom | (32'h1 << src);
         default: m = ~($urandom & $urandom & $urandom);
      endcase
      return m;
   endfunction

   // stimulus plan, reset and end of run
   initial begin : stimulus
      int unsigned      random_reqs;
      int unsigned      cur_count;
      int unsigned      phase_len;
      logic [CNT_W-1:0] value;
      logic [CHAN_W-1:0] src;
      bit               drained;

      // count still zero after reset: every source refused
      add_req(5'd0, 32'h0000_0000);
      add_req(5'd31, 32'hFFFF_FFFF);
      // count above range saturates to all channels owned
      add_cfg(6'd63);
      add_req(5'd5, 32'h0000_0000);
      add_req(5'd5, 32'h0000_0020);
      add_req(5'd31, 32'hFFFF_FFFF);
      add_req(5'd31, 32'h7FFF_FFFF);
      add_req(5'd0, 32'hFFFF_FFFE);
      add_cfg(6'd33);
      add_req(5'd16, 32'h0000_0000);
      // few streams: spill onto unowned channels and come back
      add_cfg(6'd4);
      add_req(5'd4, 32'h0000_0000);
      add_req(5'd3, 32'h0000_0008);
      add_req(5'd3, 32'h0000_0000);
      add_req(5'd3, 32'h0000_0010);
      add_req(5'd3, 32'h0000_0018);
      add_req(5'd0, 32'hFFFF_FFFF);
      add_req(5'd0, 32'h7FFF_FFFF);
      add_cfg(6'd1);
      add_req(5'd0, 32'h5555_5555);
      add_req(5'd1, 32'h0000_0000);
      add_cfg(6'd0);
      add_req(5'd31, 32'h0000_0000);
      add_cfg(6'd32);
      add_req(5'd31, 32'h0000_0000);
      add_req(5'd30, 32'hAAAA_AAAA);

      // random phases, each under a fresh stream count
      random_reqs = 0;
      drained = 1'b0;
      while (random_reqs < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: value = 6'd0;
            1: value = 6'd32;
            2: value = 6'd63;
            3: value = CNT_W'(33 + $urandom_range(0, 29));
            4: value = 6'd1;
            5: value = 6'd31;
            6: value = CNT_W'($urandom_range(0, 63));
            default: value = CNT_W'($urandom_range(2, 12));
         endcase
         add_cfg(value);
         cur_count = (value > CHAN_COUNT) ? CHAN_COUNT : value;
         phase_len = $urandom_range(40, 160);
         if (phase_len > RANDOM_ITEMS - random_reqs)
            phase_len = RANDOM_ITEMS - random_reqs;
         repeat (phase_len) begin
            if (cur_count != 0 && $urandom_range(0, 99) < 85)
               src = CHAN_W'($urandom_range(0, cur_count - 1));
            else
               src = CHAN_W'($urandom_range(0, 31));
            add_req(src, pick_mask(src));
            random_reqs++;
            // hold the sender until the pipeline has emptied
            if ((!drained && random_reqs >= 500) || $urandom_range(0, 199) == 0) begin
               add_drain();
               drained = 1'b1;
            end
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait for the plan to run out and every result to arrive
      @(posedge clock);
      while (plan_q.size() != 0 || start || predicted_routes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      err_count += predicted_routes.size();
      $display("summary: %0d requests, %0d routed, %0d relocated, %0d refused",
               n_req, n_routed, n_reloc, n_refused);
      $display("summary: %0d stream count writes, %0d mismatches", n_cfg, err_count);
      if (err_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
